// ----- rtl/pll_frequency_plan_search_core_defines.svh -----
// Assertion macros shared by the frequency plan search checker.
`ifndef PLL_FREQUENCY_PLAN_SEARCH_CORE_DEFINES_SVH
`define PLL_FREQUENCY_PLAN_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PFPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frequency plan check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PFPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frequency plan check failed");

`endif

// ----- rtl/pfps_pkg.sv -----
// Shared constants and controller/datapath interface types for the plan search.
package pfps_pkg;

  localparam int FREQ_W = 23;
  localparam int REF_W  = 18;
  localparam int INT_W  = 16;
  localparam int MOD_W  = 12;
  localparam int SEL_W  = 3;

  localparam int SCALED_W = FREQ_W + 1;
  localparam int CNT_W    = $clog2(SCALED_W);
  localparam int MREF_W   = MOD_W + REF_W;
  localparam int ERR_W    = REF_W + 10;

  localparam int MOD_LIMIT = 4095;
  localparam int ERR_SCALE = 1000;

  localparam logic [FREQ_W-1:0] TH_DIV1 = 23'd2200000;
  localparam logic [FREQ_W-1:0] TH_DIV2 = 23'd1100000;
  localparam logic [FREQ_W-1:0] TH_DIV4 = 23'd550000;
  localparam logic [FREQ_W-1:0] TH_DIV8 = 23'd275000;

  localparam logic [SEL_W-1:0] SEL_DIV1  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_DIV2  = 3'd1;
  localparam logic [SEL_W-1:0] SEL_DIV4  = 3'd2;
  localparam logic [SEL_W-1:0] SEL_DIV8  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_DIV16 = 3'd4;

  localparam logic [REF_W-1:0] REF_RESET   = 18'd25000;
  localparam logic [INT_W-1:0] INT_SAT     = 16'hFFFF;
  localparam logic [MOD_W-1:0] MOD_DEFAULT = 12'd2;

  typedef struct packed {
    logic start;
    logic div_step;
    logic srch_init;
    logic srch_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ref_zero;
    logic div_last;
    logic hit;
    logic srch_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/pfps_ctrl.sv -----
// Sequencer for the plan search: divide, modulus scan and result hand-off.
module pfps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pfps_pkg::status_t status,
  output pfps_pkg::cmd_t    cmd
);
  import pfps_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_SINIT = 5'b00100,
    ST_SRCH  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          // A zero reference has a fixed answer, so the arithmetic is skipped.
          state_nxt = status.ref_zero ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_SINIT;
        end
      end
      ST_SINIT: begin
        cmd.srch_init = 1'b1;
        state_nxt     = ST_SRCH;
      end
      ST_SRCH: begin
        if (status.hit || status.srch_last) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/pfps_datapath.sv -----
// Reference register, bit-serial divider, incremental modulus scan and result register.
module pfps_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pfps_pkg::REF_W-1:0]   cfg_wdata,
  input  logic [pfps_pkg::FREQ_W-1:0]  in_freq_khz,
  input  pfps_pkg::cmd_t               cmd,
  output pfps_pkg::status_t            status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pfps_pkg::INT_W-1:0]   out_int_value,
  output logic [pfps_pkg::MOD_W-1:0]   out_frac_value,
  output logic [pfps_pkg::MOD_W-1:0]   out_mod_value,
  output logic [pfps_pkg::SEL_W-1:0]   out_div_select
);
  import pfps_pkg::*;

  logic [REF_W-1:0]    ref_r;
  logic [SEL_W-1:0]    sel_r, sel_nxt;
  logic [SCALED_W-1:0] dq_r, dq_nxt;
  logic [REF_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [REF_W-1:0]    acc_r, acc_nxt;
  logic [MOD_W-1:0]    f_r, f_nxt;
  logic [MOD_W-1:0]    m_r, m_nxt;
  logic [MREF_W-1:0]   mref_r, mref_nxt;
  logic                out_valid_r;
  logic [INT_W-1:0]    int_r;
  logic [MOD_W-1:0]    frac_r, mod_r;
  logic [SEL_W-1:0]    dsel_r;

  logic [SEL_W-1:0]    sel_in;
  logic [REF_W:0]      trial;
  logic                trial_ge;
  logic [REF_W-1:0]    step_base;
  logic [MOD_W-1:0]    f_base;
  logic [REF_W:0]      step_sum;
  logic                step_wrap;
  logic [ERR_W-1:0]    err_lo, err_hi;
  logic                hit_lo, hit_hi, found;
  logic [INT_W-1:0]    int_sat;

  // Output divider choice from the frequency thresholds.
  always_comb begin
    if (in_freq_khz >= TH_DIV1) begin
      sel_in = SEL_DIV1;
    end else if (in_freq_khz >= TH_DIV2) begin
      sel_in = SEL_DIV2;
    end else if (in_freq_khz >= TH_DIV4) begin
      sel_in = SEL_DIV4;
    end else if (in_freq_khz >= TH_DIV8) begin
      sel_in = SEL_DIV8;
    end else begin
      sel_in = SEL_DIV16;
    end
  end

  // Restoring division, one quotient bit per cycle; the quotient shifts in below
  // the dividend bits that are still to be consumed.
  assign trial    = {rem_r, dq_r[SCALED_W-1]};
  assign trial_ge = (trial >= {1'b0, ref_r});

  // Stepping the modulus adds r to (r*m mod ref); since r < ref, one subtract
  // keeps the residue reduced and bumps floor(r*m/ref). The init step starts
  // from the m = 1 state (residue r, floor 0).
  assign step_base = cmd.srch_init ? rem_r : acc_r;
  assign f_base    = cmd.srch_init ? '0 : f_r;
  assign step_sum  = {1'b0, step_base} + {1'b0, rem_r};
  assign step_wrap = (step_sum >= {1'b0, ref_r});

  // The residue is |f*ref - r*m| and ref minus it is the error for f + 1.
  assign err_lo = ERR_W'(acc_r) * ERR_W'(ERR_SCALE);
  assign err_hi = ERR_W'(ref_r - acc_r) * ERR_W'(ERR_SCALE);
  assign hit_lo = ({{(MREF_W-ERR_W){1'b0}}, err_lo} < mref_r);
  assign hit_hi = ({{(MREF_W-ERR_W){1'b0}}, err_hi} < mref_r);
  assign found  = !status.ref_zero && (hit_lo || hit_hi);

  assign int_sat = (|dq_r[SCALED_W-1:INT_W]) ? INT_SAT : dq_r[INT_W-1:0];

  always_comb begin
    sel_nxt  = sel_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    f_nxt    = f_r;
    m_nxt    = m_r;
    mref_nxt = mref_r;
    if (cmd.start) begin
      sel_nxt = sel_in;
      dq_nxt  = SCALED_W'(in_freq_khz) << sel_in;
      rem_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = trial_ge ? REF_W'(trial - {1'b0, ref_r}) : trial[REF_W-1:0];
      dq_nxt  = {dq_r[SCALED_W-2:0], trial_ge};
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.srch_init || cmd.srch_step) begin
      acc_nxt = step_wrap ? REF_W'(step_sum - {1'b0, ref_r}) : step_sum[REF_W-1:0];
      f_nxt   = f_base + MOD_W'(step_wrap);
    end
    if (cmd.srch_init) begin
      m_nxt    = MOD_DEFAULT;
      mref_nxt = MREF_W'(ref_r) << 1;
    end
    if (cmd.srch_step) begin
      m_nxt    = m_r + 1'b1;
      mref_nxt = mref_r + MREF_W'(ref_r);
    end
  end

  always_ff @(posedge clk) begin
    sel_r  <= sel_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    f_r    <= f_nxt;
    m_r    <= m_nxt;
    mref_r <= mref_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
    end else if (cfg_we) begin
      ref_r <= cfg_wdata;
    end
  end

  // Result register: a finished plan waits here while a new item may be taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      int_r  <= status.ref_zero ? INT_SAT : int_sat;
      frac_r <= !found ? '0 : (hit_lo ? f_r : f_r + 1'b1);
      mod_r  <= found ? m_r : MOD_DEFAULT;
      dsel_r <= sel_r;
    end
  end

  assign status.ref_zero  = (ref_r == '0);
  assign status.div_last  = (cnt_r == CNT_W'(SCALED_W - 1));
  assign status.hit       = hit_lo || hit_hi;
  assign status.srch_last = (m_r == MOD_W'(MOD_LIMIT - 1));
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_int_value  = int_r;
  assign out_frac_value = frac_r;
  assign out_mod_value  = mod_r;
  assign out_div_select = dsel_r;

endmodule

// ----- rtl/pll_frequency_plan_search_core.sv -----
// Fractional-N frequency plan search: one target frequency in, one INT/FRAC/MOD plan out.
// An item goes through these steps from transfer to result: latch the frequency and
// pick the output divider, run the bit-serial divider that yields INT and the remainder,
// set up the modulus scan, scan one candidate modulus per cycle through a single pair
// of constant-multiply compares until one matches or the last modulus is reached,
// and load the result register. A modulus of 1000 or less always matches; with a zero
// reference the fixed answer goes straight to the result register. One item is worked
// on at a time; the next may be taken while the previous plan waits on the output.
module pll_frequency_plan_search_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pfps_pkg::REF_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pfps_pkg::FREQ_W-1:0]  in_freq_khz,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pfps_pkg::INT_W-1:0]   out_int_value,
  output logic [pfps_pkg::MOD_W-1:0]   out_frac_value,
  output logic [pfps_pkg::MOD_W-1:0]   out_mod_value,
  output logic [pfps_pkg::SEL_W-1:0]   out_div_select
);
  import pfps_pkg::*;

  cmd_t    cmd;
  status_t status;

  pfps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfps_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_freq_khz    (in_freq_khz),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_int_value  (out_int_value),
    .out_frac_value (out_frac_value),
    .out_mod_value  (out_mod_value),
    .out_div_select (out_div_select)
  );

endmodule

// ----- rtl/pfps_checker.sv -----
// Port-level checks for the frequency plan search core, bound to the top level.
`include "pll_frequency_plan_search_core_defines.svh"

module pfps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pfps_pkg::INT_W-1:0]   out_int_value,
  input logic [pfps_pkg::MOD_W-1:0]   out_frac_value,
  input logic [pfps_pkg::MOD_W-1:0]   out_mod_value,
  input logic [pfps_pkg::SEL_W-1:0]   out_div_select
);
  import pfps_pkg::*;

  // A stalled result keeps its payload until the transfer.
  `PFPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_int_value) && $stable(out_frac_value) && $stable(out_mod_value) && $stable(out_div_select))

  // The block works on one item at a time, so it is busy right after a transfer.
  `PFPS_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

  // Every plan has a legal modulus and a numerator that does not exceed it.
  `PFPS_ASSERT_IMP(a_frac_le_mod, out_valid, (out_mod_value >= MOD_DEFAULT) && (out_frac_value <= out_mod_value) && (out_mod_value < MOD_W'(MOD_LIMIT)))

  // The divider code names one of the five dividers.
  `PFPS_ASSERT_IMP(a_div_code, out_valid, out_div_select <= SEL_DIV16)

endmodule

bind pll_frequency_plan_search_core pfps_checker u_pfps_checker (.*);
